// ===== rtl/skf_pkg.sv =====
// skf_pkg: shared types, constants and microcode rom for the scalar kalman filter
// depends on nothing; used by rtl/scalar_kalman_filter_top.sv and bench/scalar_kalman_filter_top_test.sv

package skf_pkg;

  // fixed widths of the datapath
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned GAIN_FRAC = 16;
  localparam int unsigned GAIN_W    = GAIN_FRAC + 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PC_W      = 3;
  localparam int unsigned DIV_CNT_W = 4;

  // parameter defaults
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  localparam logic [GAIN_W-1:0]    GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(GAIN_FRAC - 1);

  // register reset values
  localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd256;
  localparam logic [DATA_W-1:0] MEAS_NOISE_RST    = 32'd65536;
  localparam logic [DATA_W-1:0] INIT_COV_RST      = 32'd65536;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COV      = 2'd2;

  // program addresses
  localparam logic [PC_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [PC_W-1:0] STEP_PRED   = 3'd1;
  localparam logic [PC_W-1:0] STEP_DEN    = 3'd2;
  localparam logic [PC_W-1:0] STEP_DIV    = 3'd3;
  localparam logic [PC_W-1:0] STEP_MUL_LO = 3'd4;
  localparam logic [PC_W-1:0] STEP_MUL_HI = 3'd5;
  localparam logic [PC_W-1:0] STEP_COMB   = 3'd6;
  localparam logic [PC_W-1:0] STEP_UPD    = 3'd7;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_PRED,
    OP_DEN,
    OP_DIV,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_COMB,
    OP_UPD
  } op_e;

  // jump taken when the condition holds, else fall through to pc + 1
  typedef enum logic [1:0] {
    CND_NEXT,
    CND_IN_WAIT,
    CND_DIV_BUSY,
    CND_OUT_FULL
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  // program rom; the last step wraps back to idle
  function automatic ctrl_t skf_ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      STEP_IDLE:   w = '{op: OP_IDLE,   cond: CND_IN_WAIT,  target: STEP_IDLE};
      STEP_PRED:   w = '{op: OP_PRED,   cond: CND_NEXT,     target: STEP_IDLE};
      STEP_DEN:    w = '{op: OP_DEN,    cond: CND_NEXT,     target: STEP_IDLE};
      STEP_DIV:    w = '{op: OP_DIV,    cond: CND_DIV_BUSY, target: STEP_DIV};
      STEP_MUL_LO: w = '{op: OP_MUL_LO, cond: CND_NEXT,     target: STEP_IDLE};
      STEP_MUL_HI: w = '{op: OP_MUL_HI, cond: CND_NEXT,     target: STEP_IDLE};
      STEP_COMB:   w = '{op: OP_COMB,   cond: CND_NEXT,     target: STEP_IDLE};
      STEP_UPD:    w = '{op: OP_UPD,    cond: CND_OUT_FULL, target: STEP_UPD};
      default:     w = '{op: OP_IDLE,   cond: CND_IN_WAIT,  target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/scalar_kalman_filter_top.sv =====
// scalar_kalman_filter_top: scalar kalman filter, microcoded datapath, valid/ready channels
// depends on rtl/skf_pkg.sv
// a new sample is taken only at idle, once the predict, denominator, divide, multiply, combine and
// update steps are through; the divide step is the 16-step restoring gain divider
// a waiting result does not block the next sample transfer; a stalled result holds the program
// reset: registers to their reset values, estimate to zero, covariance to initial_covariance

module scalar_kalman_filter_top #(
  parameter int unsigned SAMPLE_BITS = skf_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = skf_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [skf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [skf_pkg::DATA_W-1:0]           cfg_wdata_i,
  // sample channel
  input  logic                                 sample_valid_i,
  output logic                                 sample_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  // result channel
  output logic                                 result_valid_o,
  input  logic                                 result_ready_i,
  output logic signed [skf_pkg::DATA_W-1:0]    estimate_o,
  output logic [skf_pkg::GAIN_W-1:0]           gain_o
);

  localparam int unsigned DW     = skf_pkg::DATA_W;
  localparam int unsigned GW     = skf_pkg::GAIN_W;
  // sample in fixed point, then the error with one bit of headroom
  localparam int unsigned SFX_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned ERR_W  = ((SFX_W > DW) ? SFX_W : DW) + 1;
  // error times gain is split into a low unsigned and a high signed partial product
  localparam int unsigned HI_W   = ERR_W - DW;
  localparam int unsigned HIP_W  = HI_W + GW + 1;
  localparam int unsigned LOP_W  = DW + GW;
  localparam int unsigned PRD_W  = HIP_W + DW;
  localparam int unsigned COVP_W = DW + GW;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic [skf_pkg::PC_W-1:0] pc_q, pc_d;
  skf_pkg::ctrl_t           ctrl;
  logic                     jump;
  logic                     commit;     // final step may write the result register

  logic [skf_pkg::DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic                          result_valid_q;

  assign ctrl = skf_pkg::skf_ucode(pc_q);

  always_comb begin
    case (ctrl.cond)
      skf_pkg::CND_NEXT:     jump = 1'b0;
      skf_pkg::CND_IN_WAIT:  jump = !sample_valid_i;
      skf_pkg::CND_DIV_BUSY: jump = (div_cnt_q != skf_pkg::DIV_LAST);
      skf_pkg::CND_OUT_FULL: jump = result_valid_q && !result_ready_i;
      default:               jump = 1'b0;
    endcase
  end

  // program counter wraps from the last step back to idle
  assign pc_d   = jump ? ctrl.target : skf_pkg::PC_W'(pc_q + 1'b1);
  assign commit = (ctrl.op == skf_pkg::OP_UPD) && !jump;

  // sample transfer only while the program waits at idle
  assign sample_ready_o = (ctrl.op == skf_pkg::OP_IDLE);

  // ---------------------------------------------------------------------------
  // configuration and filter state
  // ---------------------------------------------------------------------------
  logic [DW-1:0]        process_noise_q;
  logic [DW-1:0]        meas_noise_q;
  logic [DW-1:0]        init_cov_q;
  logic signed [DW-1:0] estimate_q, estimate_d;
  logic [DW-1:0]        cov_q;

  logic cfg_hit;
  always_comb begin
    case (cfg_idx_i)
      skf_pkg::REG_PROCESS_NOISE: cfg_hit = 1'b1;
      skf_pkg::REG_MEAS_NOISE:    cfg_hit = 1'b1;
      skf_pkg::REG_INIT_COV:      cfg_hit = 1'b1;
      default:                    cfg_hit = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [DW-1:0]                 pp_q, pp_d;         // predicted covariance
  logic signed [ERR_W-1:0]       err_q, err_d;       // sample minus estimate
  logic [DW:0]                   den_q, den_d;       // pp + r
  logic [DW+1:0]                 rem_q, rem_d;       // divider remainder
  logic [skf_pkg::GAIN_FRAC-1:0] quot_q, quot_d;
  logic                          gain_one_q;         // r is zero: gain is exactly one
  logic [GW-1:0]                 gain_q, gain_w;
  logic [LOP_W-1:0]              lo_q, lo_d;
  logic signed [HIP_W-1:0]       hi_q, hi_d;
  logic signed [PRD_W-1:0]       prod_q, prod_d;
  logic [COVP_W-1:0]             cov_prod_q, cov_prod_d;
  logic [GW-1:0]                 gain_out_q;

  logic [DW:0]             pp_sum;
  logic signed [SFX_W-1:0] sfx;
  logic [DW+1:0]           rem_sh;
  logic                    rem_ge;
  logic signed [PRD_W-1:0] est_sum;
  logic                    est_fits;

  // saturating covariance prediction
  assign pp_sum = {1'b0, cov_q} + {1'b0, process_noise_q};
  assign pp_d   = pp_sum[DW] ? '1 : pp_sum[DW-1:0];

  assign sfx   = {sample_q, {FRAC_BITS{1'b0}}};
  assign err_d = $signed({{(ERR_W - SFX_W){sfx[SFX_W-1]}}, sfx})
               - $signed({{(ERR_W - DW){estimate_q[DW-1]}}, estimate_q});

  assign den_d = {1'b0, pp_q} + {1'b0, meas_noise_q};

  // one restoring step per cycle: shift, trial subtract
  assign rem_sh = {rem_q[DW:0], 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, den_q});

  always_comb begin
    rem_d     = rem_q;
    quot_d    = quot_q;
    div_cnt_d = div_cnt_q;
    case (ctrl.op)
      skf_pkg::OP_DEN: begin
        rem_d     = {2'b00, pp_q};
        quot_d    = '0;
        div_cnt_d = '0;
      end
      skf_pkg::OP_DIV: begin
        rem_d     = rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
        quot_d    = {quot_q[skf_pkg::GAIN_FRAC-2:0], rem_ge};
        div_cnt_d = skf_pkg::DIV_CNT_W'(div_cnt_q + 1'b1);
      end
      default: begin
      end
    endcase
  end

  assign gain_w = gain_one_q ? skf_pkg::GAIN_ONE : {1'b0, quot_q};

  // error times gain in two partial products, then combined
  assign lo_d   = err_q[DW-1:0] * gain_w;
  assign hi_d   = $signed(err_q[ERR_W-1:DW]) * $signed({1'b0, gain_q});
  assign prod_d = $signed({hi_q, {DW{1'b0}}})
                + $signed({{(PRD_W - LOP_W){1'b0}}, lo_q});

  // covariance scaled by one minus gain
  assign cov_prod_d = pp_q * (skf_pkg::GAIN_ONE - gain_q);

  // arithmetic shift gives the floor; then clamp to the signed 32 bit range
  assign est_sum  = $signed({{(PRD_W - DW){estimate_q[DW-1]}}, estimate_q})
                  + (prod_q >>> skf_pkg::GAIN_FRAC);
  assign est_fits = (&est_sum[PRD_W-1:DW-1]) || !(|est_sum[PRD_W-1:DW-1]);

  always_comb begin
    if (est_fits) begin
      estimate_d = est_sum[DW-1:0];
    end else if (est_sum[PRD_W-1]) begin
      estimate_d = {1'b1, {(DW - 1){1'b0}}};
    end else begin
      estimate_d = {1'b0, {(DW - 1){1'b1}}};
    end
  end

  // ---------------------------------------------------------------------------
  // control and state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q            <= skf_pkg::STEP_IDLE;
      div_cnt_q       <= '0;
      result_valid_q  <= 1'b0;
      process_noise_q <= skf_pkg::PROCESS_NOISE_RST;
      meas_noise_q    <= skf_pkg::MEAS_NOISE_RST;
      init_cov_q      <= skf_pkg::INIT_COV_RST;
      estimate_q      <= '0;
      cov_q           <= skf_pkg::INIT_COV_RST;
    end else begin
      pc_q      <= pc_d;
      div_cnt_q <= div_cnt_d;

      if (commit) begin
        result_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        result_valid_q <= 1'b0;
      end

      if (cfg_we_i && cfg_hit) begin
        case (cfg_idx_i)
          skf_pkg::REG_PROCESS_NOISE: process_noise_q <= cfg_wdata_i;
          skf_pkg::REG_MEAS_NOISE:    meas_noise_q    <= cfg_wdata_i;
          default:                    init_cov_q      <= cfg_wdata_i;
        endcase
        // any register write restarts the filter from the new initial covariance
        estimate_q <= '0;
        cov_q      <= (cfg_idx_i == skf_pkg::REG_INIT_COV) ? cfg_wdata_i : init_cov_q;
      end else if (commit) begin
        estimate_q <= estimate_d;
        cov_q      <= cov_prod_q[skf_pkg::GAIN_FRAC +: DW];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers, loaded by the step that owns them
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (ctrl.op)
      skf_pkg::OP_IDLE: begin
        if (sample_valid_i) begin
          sample_q <= sample_i;
        end
      end
      skf_pkg::OP_PRED: begin
        pp_q  <= pp_d;
        err_q <= err_d;
      end
      skf_pkg::OP_DEN: begin
        den_q      <= den_d;
        gain_one_q <= (meas_noise_q == '0);
        rem_q      <= rem_d;
        quot_q     <= quot_d;
      end
      skf_pkg::OP_DIV: begin
        rem_q  <= rem_d;
        quot_q <= quot_d;
      end
      skf_pkg::OP_MUL_LO: begin
        gain_q <= gain_w;
        lo_q   <= lo_d;
      end
      skf_pkg::OP_MUL_HI: begin
        hi_q <= hi_d;
      end
      skf_pkg::OP_COMB: begin
        prod_q     <= prod_d;
        cov_prod_q <= cov_prod_d;
      end
      skf_pkg::OP_UPD: begin
        if (commit) begin
          gain_out_q <= gain_q;
        end
      end
      default: begin
      end
    endcase
  end

  // estimate only moves at commit or on a register write; the user is to write only while idle,
  // which the block does not enforce, so the state register doubles as the result payload
  assign result_valid_o = result_valid_q;
  assign estimate_o     = estimate_q;
  assign gain_o         = gain_out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a transferred sample starts the program
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && sample_ready_o |=> pc_q == skf_pkg::STEP_PRED)
    else $error("sample transfer did not start the program");

  // divider remainder stays below the divisor when a real division runs
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == skf_pkg::OP_DIV) && !gain_one_q |-> rem_q < {1'b0, den_q})
    else $error("divider remainder out of range");

  // gain never exceeds one
  a_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> gain_o <= skf_pkg::GAIN_ONE)
    else $error("gain above one");

  // a result appears only from the final step
  a_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> $past(pc_q) == skf_pkg::STEP_UPD)
    else $error("result raised outside the final step");

endmodule

// ===== bench/scalar_kalman_filter_top_test.sv =====
// scalar_kalman_filter_top_test: self-checking bench for the scalar kalman filter top level
// depends on rtl/skf_pkg.sv and rtl/scalar_kalman_filter_top.sv; needs nothing else

module scalar_kalman_filter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W    = skf_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC        = skf_pkg::FRAC_BITS_DEF;
  localparam int PHASES      = 12;   // random phases after the directed part
  localparam int PHASE_ITEMS = 100;
  localparam int PRESSURE_PH = 5;    // phase in which the result side holds off
  localparam int LONG_HOLD   = 400;  // cycles of that hold-off
  localparam int SETTLE      = 30;   // settling wait once nothing is owed

  // index past the end of the register list; writes there are dropped
  localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  logic                                clk_i          = 1'b0;
  logic                                rst_ni         = 1'b0;
  logic                                cfg_we_i       = 1'b0;
  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_idx_i      = '0;
  logic [skf_pkg::DATA_W-1:0]          cfg_wdata_i    = '0;
  logic                                sample_valid_i = 1'b0;
  logic                                sample_ready_o;
  logic signed [SAMPLE_W-1:0]          sample_i       = '0;
  logic                                result_valid_o;
  logic                                result_ready_i = 1'b0;
  logic signed [skf_pkg::DATA_W-1:0]   estimate_o;
  logic [skf_pkg::GAIN_W-1:0]          gain_o;

  // handshakes between the main flow and the result sink
  bit sink_calm     = 1'b0;  // no stalls on the result side
  bit long_hold_req = 1'b0;  // ask the sink for one long hold-off
  int n_writes      = 0;

  scalar_kalman_filter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .estimate_o     (estimate_o),
    .gain_o         (gain_o)
  );

  // one filtered output: updated estimate and the gain that produced it
  typedef struct packed {
    logic signed [skf_pkg::DATA_W-1:0] estimate;
    logic [skf_pkg::GAIN_W-1:0]        gain;
  } kf_result_t;

  // fixed point kalman predictor plus the queue of outputs still owed by the block
  class kalman_scoreboard;
    logic [31:0]        proc_noise;
    logic [31:0]        meas_noise;
    logic [31:0]        init_cov;
    logic signed [31:0] est_state;
    logic [31:0]        cov_state;
    kf_result_t         pending[$];
    int errors    = 0;
    int n_samples = 0;
    int n_results = 0;
    int n_sat     = 0;  // steps whose predicted covariance clipped
    int n_zero_g  = 0;  // steps with zero gain

    function void reinit();
      est_state = '0;
      cov_state = init_cov;
    endfunction

    function void reset_model();
      proc_noise = skf_pkg::PROCESS_NOISE_RST;
      meas_noise = skf_pkg::MEAS_NOISE_RST;
      init_cov   = skf_pkg::INIT_COV_RST;
      reinit();
    endfunction

    // any known register write restarts the filter; unknown indexes change nothing
    function void load_reg(logic [skf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        skf_pkg::REG_PROCESS_NOISE: proc_noise = val;
        skf_pkg::REG_MEAS_NOISE:    meas_noise = val;
        skf_pkg::REG_INIT_COV:      init_cov   = val;
        default:                    return;
      endcase
      reinit();
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      logic [32:0] pp_sum;
      logic [31:0] pp;
      logic [63:0] den;
      logic [63:0] quot;
      logic [63:0] cov_next;
      logic [16:0] g;
      longint      err;
      longint      x;
      kf_result_t  owed;
      n_samples++;
      // predict: covariance plus process noise, clipped at all ones
      pp_sum = {1'b0, cov_state} + {1'b0, proc_noise};
      pp     = pp_sum[32] ? ALL_ONES : pp_sum[31:0];
      if (pp_sum[32]) n_sat++;
      // gain p / (p + r) in q1.16, unity when the denominator vanishes
      den = 64'(pp) + 64'(meas_noise);
      if (den == 64'd0) begin
        g = skf_pkg::GAIN_ONE;
      end else begin
        quot = {pp, 16'b0} / den;
        g    = (quot > 64'(skf_pkg::GAIN_ONE)) ? skf_pkg::GAIN_ONE : quot[16:0];
      end
      if (g == '0) n_zero_g++;
      // estimate moves by gain times error, floored, then clipped to 32 bits
      err = longint'(s) * (longint'(1) << FRAC) - longint'(est_state);
      x   = longint'(est_state) + ((err * longint'(g)) >>> skf_pkg::GAIN_FRAC);
      if (x > longint'(32'sh7FFF_FFFF)) x = longint'(32'sh7FFF_FFFF);
      if (x < longint'(32'sh8000_0000)) x = longint'(32'sh8000_0000);
      est_state = x[31:0];
      // covariance shrinks by (1 - gain)
      cov_next  = (64'(pp) * (64'(skf_pkg::GAIN_ONE) - 64'(g))) >> skf_pkg::GAIN_FRAC;
      cov_state = cov_next[31:0];
      owed.estimate = est_state;
      owed.gain     = g;
      pending.push_back(owed);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] %s", $time, msg);
    endtask

    task check_result(logic signed [31:0] est, logic [16:0] g);
      kf_result_t want;
      n_results++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d with nothing owed: estimate %0d gain %0d",
                         n_results, est, g));
        return;
      end
      want = pending.pop_front();
      if (est !== want.estimate)
        report($sformatf("result %0d estimate %0d, predicted %0d",
                         n_results, est, want.estimate));
      if (g !== want.gain)
        report($sformatf("result %0d gain %0d, predicted %0d", n_results, g, want.gain));
    endtask
  endclass

  kalman_scoreboard sb;

  // free running clock, 2 ns period
  initial begin : clock_gen
    forever #1 clk_i = ~clk_i;
  end

  // give up long after the slowest legal run would have finished
  initial begin : watchdog
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  // both channels are observed at the rising edge, before the block's registers move;
  // the result is checked ahead of the new sample so an early output cannot hide
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o && result_ready_i) sb.check_result(estimate_o, gain_o);
      if (sample_valid_i && sample_ready_o) sb.note_sample(sample_i);
    end
  end

  // result sink: alternating stretches with and without random stall bursts,
  // plus one long hold-off on request so the block backs up into the sample side
  initial begin : result_sink
    int stall_left;
    int mode_left;
    bit stalls_on;
    stall_left = 0;
    mode_left  = 0;
    stalls_on  = 1'b1;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode_left = $urandom_range(50, 300);
        stalls_on = ($urandom_range(0, 2) != 0);
      end else begin
        mode_left--;
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready_i = 1'b0;
      end else if (stalls_on && !sink_calm && $urandom_range(0, 5) == 0) begin
        stall_left     = $urandom_range(1, 12) - 1;
        result_ready_i = 1'b0;
      end else begin
        result_ready_i = 1'b1;
      end
    end
  end

  // single register write, only issued while the filter has nothing in flight
  task automatic write_cfg(input logic [skf_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    sb.load_reg(idx, val);
    n_writes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // offer one sample after gap idle cycles and hold it until the transfer;
  // valid is left high so back-to-back samples never drop it
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      sample_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    sample_valid_i = 1'b1;
    sample_i       = s;
    do @(posedge clk_i); while (!sample_ready_o);
  endtask

  task automatic send_each(input logic signed [SAMPLE_W-1:0] vals[$]);
    foreach (vals[i]) send_sample(vals[i], 0);
  endtask

  // drop valid, let every owed result come back, then let the datapath settle
  task automatic drain();
    @(negedge clk_i);
    sample_valid_i = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // noise values: extremes, sizes around one in q16.16, and anything at all
  function automatic logic [31:0] pick_reg(input bit nonzero);
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0:       v = ALL_ONES;
      1:       v = '0;
      2, 3:    v = $urandom_range(0, 32'h0002_0000);
      4, 5:    v = $urandom_range(0, 32'h0100_0000);
      default: v = $urandom;
    endcase
    if (nonzero && v == '0) v = 32'd1;  // measurement noise stays positive
    return v;
  endfunction

  // mostly a noisy random walk so the filter settles, with jumps and rails mixed in
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(
    input logic signed [SAMPLE_W-1:0] prev);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1, 2:    return SAMPLE_W'($urandom);
      default: return prev + SAMPLE_W'($urandom_range(0, 512)) - 16'sd256;
    endcase
  endfunction

  initial begin : main_flow
    logic signed [SAMPLE_W-1:0]    level;
    logic [skf_pkg::CFG_IDX_W-1:0] idx;
    bit sender_idles;
    int gap;
    int n_cfg;
    sb = new();
    sb.reset_model();
    level = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings, full-scale steps and sign flips
    send_each('{16'sd0, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sd1, -16'sd1,
                16'sd12345});
    drain();

    // process noise at all ones: predicted covariance clips every step, gain near one
    write_cfg(skf_pkg::REG_PROCESS_NOISE, ALL_ONES);
    write_cfg(skf_pkg::REG_MEAS_NOISE, 32'd1);
    send_each('{16'sh7FFF, 16'sh8000, 16'sd100});
    drain();

    // no uncertainty at all: zero covariance, zero process noise, huge r gives zero gain
    write_cfg(skf_pkg::REG_PROCESS_NOISE, 32'd0);
    write_cfg(skf_pkg::REG_INIT_COV, 32'd0);
    write_cfg(skf_pkg::REG_MEAS_NOISE, ALL_ONES);
    send_each('{16'sh7FFF, 16'sh8000});
    drain();

    // every register at its maximum
    write_cfg(skf_pkg::REG_INIT_COV, ALL_ONES);
    write_cfg(skf_pkg::REG_PROCESS_NOISE, ALL_ONES);
    send_each('{16'sd5, -16'sd5});
    drain();

    // smallest r with zero predicted covariance
    write_cfg(skf_pkg::REG_MEAS_NOISE, 32'd1);
    write_cfg(skf_pkg::REG_PROCESS_NOISE, 32'd0);
    write_cfg(skf_pkg::REG_INIT_COV, 32'd0);
    send_each('{16'sd300});
    drain();

    // write past the register list: must not restart the filter state
    write_cfg(skf_pkg::REG_PROCESS_NOISE, skf_pkg::PROCESS_NOISE_RST);
    send_each('{16'sd7000});
    drain();
    write_cfg(REG_UNUSED, ALL_ONES);
    send_each('{16'sd7, -16'sd7});
    drain();

    // random phases, each under a fresh setting
    for (int ph = 0; ph < PHASES; ph++) begin
      n_cfg = $urandom_range(1, 3);
      repeat (n_cfg) begin
        idx = skf_pkg::CFG_IDX_W'($urandom_range(0, 3));
        write_cfg(idx, pick_reg(idx == skf_pkg::REG_MEAS_NOISE));
      end
      sender_idles = ($urandom_range(0, 3) != 0);
      if (ph == PRESSURE_PH) begin
        // sender keeps offering back to back while the sink holds off
        sender_idles  = 1'b0;
        long_hold_req = 1'b1;
      end
      if (ph == PHASES - 1) begin
        // closing stretch at full rate on both sides
        sender_idles = 1'b0;
        sink_calm    = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        level = pick_sample(level);
        gap   = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        send_sample(level, gap);
      end
      drain();
    end

    $display("run covered %0d samples and %0d results under %0d register writes",
             sb.n_samples, sb.n_results, n_writes);
    $display("%0d steps clipped the predicted covariance, %0d ran at zero gain, %0d mismatches",
             sb.n_sat, sb.n_zero_g, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== scalar_kalman_filter_top.f =====
rtl/skf_pkg.sv
rtl/scalar_kalman_filter_top.sv
bench/scalar_kalman_filter_top_test.sv
